>>> hw/rtl/weighted_random_track_selector_core_macros.svh
// Assertion macros used by the track selector engine.
`ifndef WEIGHTED_RANDOM_TRACK_SELECTOR_CORE_MACROS_SVH
`define WEIGHTED_RANDOM_TRACK_SELECTOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WRTS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WRTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/wrts_pkg.sv
// Package with the types, codes and constants of the track selector.
package wrts_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = 4;
  localparam int CNT_W       = 5;
  localparam int WEIGHT_BITS = 16;
  localparam int MOOD_BITS   = 16;
  localparam int FRAC_W      = 16;
  localparam int TOTAL_W     = WEIGHT_BITS + IDX_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [1:0] {
    MODE_UNIFORM    = 2'd0,
    MODE_WEIGHTED   = 2'd1,
    MODE_SEQUENTIAL = 2'd2,
    MODE_MOOD       = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_WEIGHTED = 2'd0,
    STATUS_UNIFORM  = 2'd1,
    STATUS_EMPTY    = 2'd2
  } status_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_PICK  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_COUNT  = 2'd1,
    CFG_ACTIVE = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MULT,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 start;
    mode_t                mode;
    logic [CNT_W-1:0]     count;
    logic [MOOD_BITS-1:0] active;
    logic [FRAC_W-1:0]    fraction;
  } pick_req_t;

  typedef struct packed {
    logic                   we;
    logic [IDX_W-1:0]       index;
    logic [WEIGHT_BITS-1:0] weight;
    logic [MOOD_BITS-1:0]   moods;
  } entry_wr_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
    status_t          status;
  } pick_res_t;

endpackage

>>> hw/rtl/weighted_random_track_selector_core.sv
// Top level of the weighted random track selector with stream ports.
// A write transaction leaves the block in idle, so it is ready again at once.
// A pick with entries in use runs a weight scan, a multiply step, a roulette walk that stops at
// the hit or the last entry, and a hand-off state that holds until the result is taken; an empty
// pick goes straight to the hand-off. No new item is accepted until the block is back in idle.
// Synchronous active-high reset clears configuration and control state.
module weighted_random_track_selector_core
  import wrts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // entry_index, entry_weight, entry_moods, random_fraction, zero pad
  input  logic [55:0]           s_axis_tdata,
  // operation
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // picked_index, zero pad
  output logic [7:0]            m_axis_tdata,
  // pick_status
  output logic [1:0]            m_axis_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  mode_t                selection_mode;
  logic [CNT_W-1:0]     track_count;
  logic [MOOD_BITS-1:0] active_moods;

  logic                 out_valid;
  logic [IDX_W-1:0]     out_idx;
  status_t              out_status;

  pick_req_t            req;
  entry_wr_t            wr;
  pick_res_t            res;
  logic                 idle;
  logic                 res_take;
  logic                 in_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      selection_mode <= MODE_UNIFORM;
      track_count    <= '0;
      active_moods   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:   selection_mode <= mode_t'(cfg_data[1:0]);
        CFG_COUNT:  track_count    <= cfg_data[CNT_W-1:0];
        CFG_ACTIVE: active_moods   <= cfg_data[MOOD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = idle;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    req.start    = in_fire && (op_t'(s_axis_tuser[0]) == OP_PICK);
    req.mode     = selection_mode;
    req.count    = (track_count > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : track_count;
    req.active   = active_moods;
    req.fraction = s_axis_tdata[51:36];
    wr.we        = in_fire && (op_t'(s_axis_tuser[0]) == OP_WRITE);
    wr.index     = s_axis_tdata[3:0];
    wr.weight    = s_axis_tdata[19:4];
    wr.moods     = s_axis_tdata[35:20];
  end

  assign res_take = res.valid && (!out_valid || m_axis_tready);

  wrts_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .wr       (wr),
    .res_take (res_take),
    .res      (res),
    .idle     (idle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_idx    <= res.index;
      out_status <= res.status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(8 - IDX_W){1'b0}}, out_idx};
  assign m_axis_tuser  = out_status;

endmodule

>>> hw/rtl/wrts_engine.sv
// Entry table and the sequencer that totals weights and walks the roulette.
`include "weighted_random_track_selector_core_macros.svh"

module wrts_engine
  import wrts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  pick_req_t req,
  input  entry_wr_t wr,
  input  logic      res_take,
  output pick_res_t res,
  output logic      idle
);

  logic [WEIGHT_BITS-1:0] weight_table [MAX_ENTRIES];
  logic [MOOD_BITS-1:0]   mood_table [MAX_ENTRIES];

  state_t                 state;
  state_t                 state_next;
  logic [CNT_W-1:0]       pos;
  logic [CNT_W-1:0]       n_r;
  logic [MOOD_BITS-1:0]   act_r;
  logic [FRAC_W-1:0]      frac_r;
  logic                   weighted_mode;
  logic                   filt_mode;
  logic                   use_flt;
  logic                   uni;
  logic [TOTAL_W-1:0]     acc_all;
  logic [TOTAL_W-1:0]     acc_flt;
  logic [CNT_W-1:0]       cnt_flt;
  logic [TOTAL_W-1:0]     target;
  logic [TOTAL_W-1:0]     run;
  logic [IDX_W-1:0]       last;
  logic [IDX_W-1:0]       res_idx;
  status_t                res_status;

  logic [WEIGHT_BITS-1:0] cur_w;
  logic                   match;
  logic                   at_end;
  logic                   use_flt_c;
  logic [TOTAL_W-1:0]     total_c;
  logic [CNT_W-1:0]       cnt_c;
  logic                   uni_c;
  logic [TOTAL_W-1:0]     operand;
  logic [FRAC_W+TOTAL_W-1:0] product;
  logic                   cand;
  logic [TOTAL_W-1:0]     incr;
  logic [TOTAL_W-1:0]     run_sum;
  logic                   hit;

  assign cur_w   = weight_table[pos[IDX_W-1:0]];
  assign match   = (mood_table[pos[IDX_W-1:0]] & act_r) != '0;
  assign at_end  = (pos == n_r - CNT_W'(1));

  assign use_flt_c = filt_mode && (cnt_flt != '0);
  assign total_c   = use_flt_c ? acc_flt : acc_all;
  assign cnt_c     = use_flt_c ? cnt_flt : n_r;
  assign uni_c     = !weighted_mode || (total_c == '0);
  assign operand   = uni_c ? TOTAL_W'(cnt_c) : total_c;
  assign product   = FRAC_W'(frac_r) * operand;

  assign cand    = !use_flt || match;
  assign incr    = uni ? TOTAL_W'(1) : TOTAL_W'(cur_w);
  assign run_sum = run + incr;
  assign hit     = cand && (target < run_sum);

  always_ff @(posedge clk) begin
    if (wr.we) begin
      weight_table[wr.index] <= wr.weight;
      mood_table[wr.index]   <= wr.moods;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.start) begin
          state_next = (req.count == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (at_end) begin
          state_next = ST_MULT;
        end
      end
      ST_MULT: state_next = ST_WALK;
      ST_WALK: begin
        if (hit || at_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    idle       = (state == ST_IDLE);
    res.valid  = (state == ST_DONE);
    res.index  = res_idx;
    res.status = res_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        pos           <= '0;
        n_r           <= req.count;
        act_r         <= req.active;
        frac_r        <= req.fraction;
        weighted_mode <= (req.mode == MODE_WEIGHTED) || (req.mode == MODE_MOOD);
        filt_mode     <= (req.mode == MODE_MOOD) && (req.active != '0);
        acc_all       <= '0;
        acc_flt       <= '0;
        cnt_flt       <= '0;
        res_idx       <= '0;
        res_status    <= STATUS_EMPTY;
      end
      ST_SCAN: begin
        acc_all <= acc_all + TOTAL_W'(cur_w);
        if (match) begin
          acc_flt <= acc_flt + TOTAL_W'(cur_w);
          cnt_flt <= cnt_flt + CNT_W'(1);
        end
        if (!at_end) begin
          pos <= pos + CNT_W'(1);
        end
      end
      ST_MULT: begin
        pos     <= '0;
        run     <= '0;
        last    <= '0;
        use_flt <= use_flt_c;
        uni     <= uni_c;
        target  <= product[FRAC_W+TOTAL_W-1:FRAC_W];
      end
      ST_WALK: begin
        res_status <= uni ? STATUS_UNIFORM : STATUS_WEIGHTED;
        if (cand) begin
          run  <= run_sum;
          last <= pos[IDX_W-1:0];
        end
        if (hit || (at_end && cand)) begin
          res_idx <= pos[IDX_W-1:0];
        end else if (at_end) begin
          res_idx <= last;
        end else begin
          pos <= pos + CNT_W'(1);
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  `WRTS_ASSERT_SAME(a_start_idle, clk, rst, req.start, state == ST_IDLE, "pick started while busy")
  `WRTS_ASSERT_NEXT(a_empty_done, clk, rst, req.start && (req.count == '0) && idle, state == ST_DONE && res_status == STATUS_EMPTY, "empty library not reported at once")
  `WRTS_ASSERT_SAME(a_walk_range, clk, rst, state == ST_WALK || state == ST_SCAN, pos < n_r, "table position beyond entry count")
  `WRTS_ASSERT_NEXT(a_done_hold, clk, rst, state == ST_DONE && !res_take, state == ST_DONE && $stable(res_idx), "result dropped before taken")
  `WRTS_ASSERT_SAME(a_empty_zero, clk, rst, res.valid && res.status == STATUS_EMPTY, res.index == '0, "empty result with nonzero index")

endmodule

>>> verif/weighted_random_track_selector_core_tb.sv
// Self-checking testbench for the weighted random track selector: predicts every pick.
`timescale 1ns / 1ps

module weighted_random_track_selector_core_tb;
  import wrts_pkg::*;

  localparam int SETTLE_CYCLES  = 2 * MAX_ENTRIES + 8;
  localparam int LONG_HOLD      = 500;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASES         = 40;

  typedef enum int {
    SINK_ALWAYS,
    SINK_COIN,
    SINK_RUNS,
    SINK_SPARSE
  } sink_style_e;

  class pick_scoreboard;
    typedef struct {
      logic [IDX_W-1:0] index;
      status_t          status;
    } pick_t;

    logic [WEIGHT_BITS-1:0] weights [MAX_ENTRIES];
    logic [MOOD_BITS-1:0]   moods [MAX_ENTRIES];
    mode_t                  mode;
    logic [CNT_W-1:0]       count;
    logic [MOOD_BITS-1:0]   active;
    pick_t                  pending_picks[$];
    int                     errors;
    int                     writes;
    int                     picks;
    int                     settings;
    int                     outcome [3];

    function new();
      mode = MODE_UNIFORM;
      count = '0;
      active = '0;
      errors = 0;
      writes = 0;
      picks = 0;
      settings = 1;
      outcome = '{0, 0, 0};
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    function int pending();
      return pending_picks.size();
    endfunction

    function void set_config(mode_t m, logic [CNT_W-1:0] c, logic [MOOD_BITS-1:0] a);
      mode = m;
      count = c;
      active = a;
      settings++;
    endfunction

    function logic [IDX_W-1:0] nth_candidate(logic [15:0] cand, logic [FRAC_W-1:0] frac);
      int c;
      int k;
      logic [IDX_W-1:0] last;
      c = $countones(cand);
      k = (int'(frac) * c) >> 16;
      last = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (cand[i]) begin
          last = i[IDX_W-1:0];
          if (k == 0) return last;
          k--;
        end
      end
      return last;
    endfunction

    function void predict_pick(logic [FRAC_W-1:0] frac);
      logic [15:0] cand;
      logic [15:0] hits;
      int n;
      longint total;
      longint target;
      longint run;
      pick_t p;
      n = (count > MAX_ENTRIES) ? MAX_ENTRIES : int'(count);
      p.index = '0;
      if (n == 0) begin
        p.status = STATUS_EMPTY;
      end else begin
        cand = 16'((32'h1 << n) - 1);
        if (mode == MODE_MOOD && active != 0) begin
          hits = '0;
          for (int i = 0; i < MAX_ENTRIES; i++)
            hits[i] = cand[i] && ((moods[i] & active) != 0);
          if (hits != 0) cand = hits;
        end
        total = 0;
        if (mode == MODE_WEIGHTED || mode == MODE_MOOD) begin
          for (int i = 0; i < MAX_ENTRIES; i++)
            if (cand[i]) total += weights[i];
        end
        if (total != 0) begin
          target = (longint'(frac) * total) >> 16;
          run = 0;
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (cand[i]) begin
              p.index = i[IDX_W-1:0];
              run += weights[i];
              if (target < run) break;
            end
          end
          p.status = STATUS_WEIGHTED;
        end else begin
          p.index = nth_candidate(cand, frac);
          p.status = STATUS_UNIFORM;
        end
      end
      outcome[int'(p.status)]++;
      pending_picks.push_back(p);
    endfunction

    function void note_input(op_t op, logic [IDX_W-1:0] idx, logic [WEIGHT_BITS-1:0] w,
                             logic [MOOD_BITS-1:0] m, logic [FRAC_W-1:0] frac);
      if (op == OP_WRITE) begin
        weights[idx] = w;
        moods[idx] = m;
        writes++;
      end else begin
        picks++;
        predict_pick(frac);
      end
    endfunction

    task check_result(logic [IDX_W-1:0] index, logic [1:0] status);
      pick_t p;
      if (pending_picks.size() == 0) begin
        report($sformatf("result index %0d status %0d with no pick outstanding",
                         index, status));
      end else begin
        p = pending_picks.pop_front();
        if (index !== p.index)
          report($sformatf("picked_index %0d, predicted %0d", index, p.index));
        if (status !== p.status)
          report($sformatf("pick_status %0d, predicted %0d", status, p.status));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [55:0]           s_axis_tdata;
  logic [0:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [7:0]            m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pick_scoreboard sb = new();
  sink_style_e    sink_style = SINK_ALWAYS;
  bit             hold_request = 1'b0;
  bit             tx_bursty = 1'b0;
  int             burst_left = 0;
  int             quiet_cycles = 0;

  weighted_random_track_selector_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic send_item(op_t op, logic [IDX_W-1:0] idx, logic [WEIGHT_BITS-1:0] w,
                           logic [MOOD_BITS-1:0] m, logic [FRAC_W-1:0] frac);
    s_axis_tdata <= {4'b0, frac, m, w, idx};
    s_axis_tuser <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(op, idx, w, m, frac);
    if (tx_bursty) begin
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(10, 45)) @(posedge clk);
        else
          repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(mode_t mode, logic [CNT_W-1:0] cnt, logic [MOOD_BITS-1:0] act,
                            bit poke_unused);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_index <= CFG_COUNT;
    cfg_data <= CFG_DATA_W'(cnt);
    @(posedge clk);
    cfg_index <= CFG_ACTIVE;
    cfg_data <= act;
    @(posedge clk);
    if (poke_unused) begin
      cfg_index <= CFG_NONE;
      cfg_data <= CFG_DATA_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sb.set_config(mode, cnt, act);
  endtask

  task automatic directed_picks(mode_t mode, logic [CNT_W-1:0] cnt, logic [MOOD_BITS-1:0] act,
                                logic [FRAC_W-1:0] f0, logic [FRAC_W-1:0] f1);
    settle();
    write_regs(mode, cnt, act, mode == MODE_UNIFORM);
    send_item(OP_PICK, '0, '0, '0, f0);
    send_item(OP_PICK, '0, '0, '0, f1);
  endtask

  initial begin : result_sink
    int hold_left;
    int run_left;
    int sparse_phase;
    bit run_ready;
    hold_left = 0;
    run_left = 0;
    sparse_phase = 0;
    run_ready = 1'b1;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata[IDX_W-1:0], m_axis_tuser);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (sink_style)
          SINK_ALWAYS: m_axis_tready <= 1'b1;
          SINK_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
          SINK_RUNS: begin
            if (run_left == 0) begin
              run_left = $urandom_range(1, 30);
              run_ready = !run_ready;
            end
            run_left--;
            m_axis_tready <= run_ready;
          end
          default: begin
            sparse_phase = (sparse_phase + 1) % 4;
            m_axis_tready <= (sparse_phase == 0);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TIMEOUT: %0d cycles without a transaction", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    mode_t                  mode;
    logic [CNT_W-1:0]       cnt;
    logic [MOOD_BITS-1:0]   act;
    logic [WEIGHT_BITS-1:0] w;
    logic [MOOD_BITS-1:0]   m;
    logic [FRAC_W-1:0]      frac;
    op_t                    op;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_MODE;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration has no entries in use, so the pick reports an empty library.
    send_item(OP_PICK, '0, '0, '0, '0);
    // Entry 0 has zero weight, entry 7 carries every mood but the top one, entry 15 none.
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      send_item(OP_WRITE, i[IDX_W-1:0],
                (i == 0) ? 16'h0000 : 16'(16'hFFFF >> (i - 1)),
                (i == 15) ? 16'h0000 : (i == 7) ? 16'h7FFF : 16'(16'h1 << i),
                '0);
    end
    directed_picks(MODE_UNIFORM, 5'd16, 16'h0000, 16'h0000, 16'hFFFF);
    directed_picks(MODE_WEIGHTED, 5'd16, 16'h0000, 16'h0000, 16'hFFFF);
    directed_picks(MODE_SEQUENTIAL, 5'd31, 16'hFFFF, 16'h8000, 16'hFFFF);
    directed_picks(MODE_MOOD, 5'd16, 16'h8000, 16'h0000, 16'hFFFF);
    directed_picks(MODE_MOOD, 5'd16, 16'h0001, 16'h1234, 16'hFFFF);
    directed_picks(MODE_WEIGHTED, 5'd1, 16'h0000, 16'h0000, 16'hFFFF);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      mode = mode_t'(ph % 4);
      if (ph == 3)
        cnt = 5'd0;
      else if (ph % 7 == 0)
        cnt = 5'd16;
      else if (ph % 11 == 5)
        cnt = CNT_W'($urandom_range(17, 31));
      else
        cnt = CNT_W'($urandom_range(1, 16));
      case ($urandom_range(0, 4))
        0: act = 16'h0000;
        1: act = 16'hFFFF;
        2: act = 16'(16'h1 << $urandom_range(0, 15));
        default: act = 16'($urandom);
      endcase
      write_regs(mode, cnt, act, ph % 9 == 0);
      tx_bursty = (ph % 3 != 0);
      burst_left = $urandom_range(1, 12);
      sink_style = sink_style_e'($urandom_range(0, 3));
      if (ph == 6) begin
        tx_bursty = 1'b0;
        sink_style = SINK_ALWAYS;
        hold_request = 1'b1;
      end
      repeat ($urandom_range(35, 65)) begin
        op = ($urandom_range(0, 9) < 3) ? OP_WRITE : OP_PICK;
        case ($urandom_range(0, 7))
          0, 1: w = 16'h0000;
          2: w = 16'hFFFF;
          3, 4: w = 16'($urandom_range(1, 255));
          default: w = 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
          0: m = 16'h0000;
          1: m = 16'(16'h1 << $urandom_range(0, 15));
          default: m = 16'($urandom);
        endcase
        case ($urandom_range(0, 7))
          0: frac = 16'h0000;
          1: frac = 16'hFFFF;
          default: frac = 16'($urandom);
        endcase
        send_item(op, IDX_W'($urandom_range(0, 15)), w, m, frac);
      end
    end

    settle();
    if (sb.pending() != 0)
      sb.report($sformatf("%0d predicted picks never arrived", sb.pending()));
    $display("Covered %0d entry writes and %0d picks over %0d register settings.",
             sb.writes, sb.picks, sb.settings);
    $display("Picks: %0d weighted, %0d uniform, %0d empty; one %0d-cycle output hold-off.",
             sb.outcome[0], sb.outcome[1], sb.outcome[2], LONG_HOLD);
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/wrts_pkg.sv
hw/rtl/wrts_engine.sv
hw/rtl/weighted_random_track_selector_core.sv
verif/weighted_random_track_selector_core_tb.sv
